// ===== rtl/pgft_pkg.sv =====
// Shared types, constants and helpers of the pulse-group frame transmitter.
`default_nettype none
package pgft_pkg;

  // Slots in one pulse group; the code registers are six bits wide.
  localparam int SLOTS_PER_GROUP = 6;
  localparam int CodeW  = 6;
  localparam int GroupW = SLOTS_PER_GROUP;
  localparam int SlotW  = $clog2(SLOTS_PER_GROUP + 1);

  localparam int FrameW   = 32;
  localparam int GroupCntW = 6;
  // Start group, one group per frame bit, end group.
  localparam logic [GroupCntW-1:0] FrameGroups = GroupCntW'(FrameW + 2);

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgStartCode  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgZeroCode   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOneCode    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgEndCode    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgHeaderByte = 3'd4;

  localparam logic [CodeW-1:0] StartCodeRst  = 6'd43;
  localparam logic [CodeW-1:0] ZeroCodeRst   = 6'd47;
  localparam logic [CodeW-1:0] OneCodeRst    = 6'd53;
  localparam logic [CodeW-1:0] EndCodeRst    = 6'd45;
  localparam logic [7:0]       HeaderByteRst = 8'd170;

  typedef enum logic [1:0] {
    PULSE_NONE = 2'd0,
    PULSE_SYNC = 2'd1,
    PULSE_LONG = 2'd2
  } pulse_e;

  typedef struct packed {
    logic [CodeW-1:0] start_code;
    logic [CodeW-1:0] zero_code;
    logic [CodeW-1:0] one_code;
    logic [CodeW-1:0] end_code;
    logic [7:0]       header_byte;
  } cfg_t;

  typedef struct packed {
    pulse_e pulse;
    logic   led_on;
    logic   frame_done;
  } result_t;

  // Fits a six-bit code to the group width: missing high slots are zero,
  // surplus high bits are dropped.
  function automatic logic [GroupW-1:0] fit_code(logic [CodeW-1:0] code);
    logic [CodeW+GroupW-1:0] ext;
    ext = {{GroupW{1'b0}}, code};
    return ext[GroupW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pgft_cfg_regs.sv =====
// Configuration registers of the frame transmitter.
`default_nettype none
module pgft_cfg_regs
  import pgft_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartCode:  cfg_d.start_code  = cfg_wdata_i[CodeW-1:0];
        CfgZeroCode:   cfg_d.zero_code   = cfg_wdata_i[CodeW-1:0];
        CfgOneCode:    cfg_d.one_code    = cfg_wdata_i[CodeW-1:0];
        CfgEndCode:    cfg_d.end_code    = cfg_wdata_i[CodeW-1:0];
        CfgHeaderByte: cfg_d.header_byte = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code  <= StartCodeRst;
      cfg_q.zero_code   <= ZeroCodeRst;
      cfg_q.one_code    <= OneCodeRst;
      cfg_q.end_code    <= EndCodeRst;
      cfg_q.header_byte <= HeaderByteRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/pgft_slot_engine.sv =====
// Frame state and per-beat slot sequencing of the frame transmitter.
`default_nettype none
module pgft_slot_engine
  import pgft_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic        opcode_i,
  input  wire logic [15:0] level_i,
  input  wire cfg_t        cfg_i,
  output result_t          res_o
);

  logic [FrameW-1:0]    pend_q, pend_d;
  logic [FrameW-1:0]    fshift_q, fshift_d;
  logic [GroupW-1:0]    gshift_q, gshift_d;
  logic [SlotW-1:0]     slots_q, slots_d;
  logic [GroupCntW-1:0] groups_q, groups_d;
  logic                 running_q, running_d;
  logic                 lamp_q, lamp_d;

  logic [7:0]           sum;
  logic [SlotW-1:0]     slots_mid;
  pulse_e               pulse;
  logic                 done;

  assign sum = cfg_i.header_byte + level_i[15:8] + level_i[7:0];

  always_comb begin
    pend_d    = pend_q;
    fshift_d  = fshift_q;
    gshift_d  = gshift_q;
    slots_d   = slots_q;
    groups_d  = groups_q;
    running_d = running_q;
    lamp_d    = lamp_q;
    slots_mid = slots_q;
    pulse     = PULSE_NONE;
    done      = 1'b0;

    if (opcode_i) begin
      pend_d    = {cfg_i.header_byte, level_i, sum};
      groups_d  = FrameGroups;
      running_d = 1'b1;
    end else if (running_q) begin
      // An empty group slot count at the first beat of a frame from idle
      // means the sync pulse goes out before the start group.
      if (slots_q == '0) begin
        pulse = PULSE_SYNC;
      end else begin
        pulse     = gshift_q[GroupW-1] ? PULSE_LONG : PULSE_NONE;
        gshift_d  = gshift_q << 1;
        slots_mid = slots_q - SlotW'(1);
      end
      slots_d = slots_mid;
      if (slots_mid == '0) begin
        if (groups_q == '0) begin
          lamp_d    = 1'b0;
          running_d = 1'b0;
          done      = 1'b1;
        end else begin
          slots_d = SlotW'(SLOTS_PER_GROUP);
          if (groups_q == FrameGroups) begin
            lamp_d   = 1'b1;
            fshift_d = pend_q;
            gshift_d = fit_code(cfg_i.start_code);
          end else if (groups_q == GroupCntW'(1)) begin
            gshift_d = fit_code(cfg_i.end_code);
          end else begin
            gshift_d = fit_code(fshift_q[FrameW-1] ? cfg_i.one_code : cfg_i.zero_code);
            fshift_d = fshift_q << 1;
          end
          groups_d = groups_q - GroupCntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      fshift_q  <= '0;
      gshift_q  <= '0;
      slots_q   <= '0;
      groups_q  <= '0;
      running_q <= 1'b0;
      lamp_q    <= 1'b0;
    end else if (step_i) begin
      pend_q    <= pend_d;
      fshift_q  <= fshift_d;
      gshift_q  <= gshift_d;
      slots_q   <= slots_d;
      groups_q  <= groups_d;
      running_q <= running_d;
      lamp_q    <= lamp_d;
    end
  end

  assign res_o.pulse      = pulse;
  assign res_o.led_on     = lamp_d;
  assign res_o.frame_done = done;

endmodule
`default_nettype wire

// ===== rtl/pulse_group_frame_transmitter_unit.sv =====
// Top level of the pulse-group frame transmitter: beat registers and wiring.
`default_nettype none
// One input beat is taken every clock cycle unless the input side stalls, and
// each gives exactly one result beat: the beat is captured in an input
// register, the slot engine's short logic computes the slot and the new
// frame state from it, and the result register presents it.
// While the result register is stalled, one further beat is held in the
// input register, after which the input side stalls as well. A load beat
// builds the frame and arms the group counter; each tick beat of a running
// frame sends one pulse slot: sync pulse, start group, 32 data groups, end group.
// Configuration writes take effect at the next edge and are meant for idle.
module pulse_group_frame_transmitter_unit
  import pgft_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic                opcode_i,
  input  wire logic [15:0]         level_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [1:0]          pulse_o,
  output      logic                led_on_o,
  output      logic                frame_done_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  result_t res;

  logic        in_vld_q;
  logic        opcode_q;
  logic [15:0] level_q;
  logic        out_vld_q;
  result_t     out_q;
  logic        step;
  logic        in_take;

  // The held beat moves on whenever the result register is free or emptying.
  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  pgft_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  pgft_slot_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .opcode_i(opcode_q),
    .level_i (level_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      opcode_q <= opcode_i;
      level_q  <= level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign pulse_o      = out_q.pulse;
  assign led_on_o     = out_q.led_on;
  assign frame_done_o = out_q.frame_done;

`ifndef SYNTHESIS
  // The lamp goes out on the beat that ends a frame.
  a_done_lamp_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> !led_on_o)
    else $error("frame end reported with lamp still on");

  // The last slot of the end group is a data slot, never the sync pulse.
  a_done_not_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> pulse_o != PULSE_SYNC)
    else $error("frame end reported on a sync slot");

  // Input side stalls only while a beat is held and cannot move on.
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled without a blocked held beat");

  // A beat that is stepped leaves a result waiting in the next cycle.
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("processed beat produced no result");
`endif

endmodule
`default_nettype wire

// ===== tb/pgft_checker.sv =====
// Checker for the pulse-group frame transmitter: predicts every result beat and compares.
module pgft_checker
  import pgft_pkg::*;
#(
  parameter logic LOAD_OP = 1'b1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                opcode_i,
  input  logic [15:0]         level_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [1:0]          pulse_i,
  input  logic                led_on_i,
  input  logic                frame_done_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                 cfg;
  logic [FrameW-1:0]    pending_frame;
  logic [FrameW-1:0]    frame_bits;
  logic [GroupW-1:0]    code_bits;
  logic [SlotW-1:0]     slots_left;
  logic [GroupCntW-1:0] groups_left;
  logic                 running;
  logic                 lamp;
  result_t              slot_q[$];
  result_t              want;
  int                   fails;

  function automatic void load_group(input logic [CodeW-1:0] code);
    // A code wider than the group loses its high bits; a narrower one is zero-filled.
    code_bits  = GroupW'(code);
    slots_left = SlotW'(SLOTS_PER_GROUP);
  endfunction

  // Advances the transmitter by one beat and returns the slot it sends.
  function automatic result_t next_slot(input logic op, input logic [15:0] lvl);
    result_t    r;
    logic [7:0] sum;
    r.pulse      = PULSE_NONE;
    r.frame_done = 1'b0;
    if (op == LOAD_OP) begin
      sum           = cfg.header_byte + lvl[15:8] + lvl[7:0];
      pending_frame = {cfg.header_byte, lvl, sum};
      groups_left   = FrameGroups;
      running       = 1'b1;
    end else if (running) begin
      if (slots_left == '0) begin
        r.pulse = PULSE_SYNC;
      end else begin
        r.pulse    = code_bits[GroupW-1] ? PULSE_LONG : PULSE_NONE;
        code_bits  = code_bits << 1;
        slots_left = slots_left - 1'b1;
      end
      if (slots_left == '0) begin
        if (groups_left == '0) begin
          lamp         = 1'b0;
          running      = 1'b0;
          r.frame_done = 1'b1;
        end else begin
          if (groups_left == FrameGroups) begin
            // A fresh frame is only taken over when its start group is chosen.
            lamp       = 1'b1;
            frame_bits = pending_frame;
            load_group(cfg.start_code);
          end else if (groups_left == 1) begin
            load_group(cfg.end_code);
          end else begin
            load_group(frame_bits[FrameW-1] ? cfg.one_code : cfg.zero_code);
            frame_bits = frame_bits << 1;
          end
          groups_left = groups_left - 1'b1;
        end
      end
    end
    r.led_on = lamp;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg           = '{start_code: StartCodeRst, zero_code: ZeroCodeRst,
                        one_code: OneCodeRst, end_code: EndCodeRst,
                        header_byte: HeaderByteRst};
      pending_frame = '0;
      frame_bits    = '0;
      code_bits     = '0;
      slots_left    = '0;
      groups_left   = '0;
      running       = 1'b0;
      lamp          = 1'b0;
      fails         = 0;
      slot_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStartCode:  cfg.start_code  = cfg_wdata_i[CodeW-1:0];
          CfgZeroCode:   cfg.zero_code   = cfg_wdata_i[CodeW-1:0];
          CfgOneCode:    cfg.one_code    = cfg_wdata_i[CodeW-1:0];
          CfgEndCode:    cfg.end_code    = cfg_wdata_i[CodeW-1:0];
          CfgHeaderByte: cfg.header_byte = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (slot_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: unexpected result beat: pulse=%0d led_on=%0b frame_done=%0b",
                     $realtime, pulse_i, led_on_i, frame_done_i);
          end
        end else begin
          want = slot_q.pop_front();
          if (pulse_i !== want.pulse || led_on_i !== want.led_on ||
              frame_done_i !== want.frame_done) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: mismatch: expected pulse=%0d led_on=%0b frame_done=%0b",
                       $realtime, want.pulse, want.led_on, want.frame_done);
              $display("%0t:           got      pulse=%0d led_on=%0b frame_done=%0b",
                       $realtime, pulse_i, led_on_i, frame_done_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        slot_q.push_back(next_slot(opcode_i, level_i));
      end
      fail_count_o <= fails;
      pending_o    <= slot_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench: clock, reset, stimulus, stall patterns and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pgft_pkg::*;

  localparam logic OpTick = 1'b0;
  localparam logic OpLoad = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgUnused = '1;
  localparam int FrameTicks = 1 + 34 * SLOTS_PER_GROUP;
  localparam int QuietLimit = 2000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                opcode;
  logic [15:0]         level;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          pulse;
  logic                led_on;
  logic                frame_done;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int                  fail_count;
  int                  pending;
  int                  send_idle_pct;
  int                  stall_pct;
  int                  quiet_cycles;

  pulse_group_frame_transmitter_unit u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .level_i      (level),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pulse_o      (pulse),
    .led_on_o     (led_on),
    .frame_done_o (frame_done),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  pgft_checker #(
    .LOAD_OP (OpLoad)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .opcode_i     (opcode),
    .level_i      (level),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .pulse_i      (pulse),
    .led_on_i     (led_on),
    .frame_done_i (frame_done),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Ends the run when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Presents one beat, with a random gap first, and returns once it is taken.
  task automatic send_beat(input logic op, input logic [15:0] lvl);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    level    <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drops valid and waits until every result beat has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_all(input logic [7:0] start_c, input logic [7:0] zero_c,
                           input logic [7:0] one_c, input logic [7:0] end_c,
                           input logic [7:0] header);
    write_reg(CfgStartCode, start_c);
    write_reg(CfgZeroCode, zero_c);
    write_reg(CfgOneCode, one_c);
    write_reg(CfgEndCode, end_c);
    write_reg(CfgHeaderByte, header);
    // An index past the last register must leave everything untouched.
    write_reg(CfgIdxW'($urandom_range(int'(CfgUnused), int'(CfgHeaderByte) + 1)),
              CfgDataW'($urandom));
  endtask

  function automatic logic [15:0] pick_level();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hffff;
    return 16'($urandom_range(65535));
  endfunction

  // Mostly whole frames, some cut short by a fresh load, and a little noise.
  task automatic random_frames(input int beats);
    int sent;
    int r;
    int n;
    sent = 0;
    while (sent < beats) begin
      r = $urandom_range(99);
      if (r < 50) begin
        send_beat(OpLoad, pick_level());
        // A frame that follows a cut-short one first finishes the old group.
        repeat (FrameTicks + SLOTS_PER_GROUP) send_beat(OpTick, 16'($urandom));
        n = $urandom_range(3);
        repeat (n) send_beat(OpTick, 16'($urandom));
        sent += 1 + FrameTicks + SLOTS_PER_GROUP + n;
      end else if (r < 80) begin
        send_beat(OpLoad, pick_level());
        n = $urandom_range(FrameTicks - 1, 1);
        repeat (n) send_beat(OpTick, 16'($urandom));
        sent += n + 1;
      end else begin
        n = $urandom_range(8, 1);
        repeat (n) begin
          send_beat(($urandom_range(99) < 30) ? OpLoad : OpTick, pick_level());
        end
        sent += n;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    opcode        = OpTick;
    level         = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CfgStartCode;
    cfg_wdata     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    quiet_cycles  = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: ticks while idle, loads at the level extremes, loads mid-frame
    // and back to back.
    send_beat(OpTick, 16'hffff);
    send_beat(OpTick, 16'h0000);
    send_beat(OpLoad, 16'h0000);
    repeat (5) send_beat(OpTick, 16'h0000);
    send_beat(OpLoad, 16'hffff);
    repeat (4) send_beat(OpTick, 16'hffff);
    send_beat(OpLoad, 16'h00ff);
    send_beat(OpLoad, 16'hff00);
    repeat (3) send_beat(OpTick, 16'h5a5a);
    send_beat(OpLoad, 16'h8001);
    repeat (2) send_beat(OpTick, 16'ha5a5);

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: write_all(8'd43, 8'd47, 8'd53, 8'd45, 8'd170);
        1: write_all(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        2: write_all(8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        default: write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom));
      endcase
      case (phase)
        1: begin
          send_idle_pct = 71;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 71;
        end
        3: begin
          send_idle_pct = 11;
          stall_pct     = 11;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      random_frames(150);
    end

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pgft_pkg.sv
rtl/pgft_cfg_regs.sv
rtl/pgft_slot_engine.sv
rtl/pulse_group_frame_transmitter_unit.sv
tb/pgft_checker.sv
tb/testbench.sv
